// ----- design/mxh64_pkg.sv -----
package mxh64_pkg;

  localparam logic [63:0] HashMul   = 64'hc6a4a7935bd1e995;
  localparam int unsigned HashShift = 47;
  localparam logic [31:0] HashMulLo = HashMul[31:0];
  localparam logic [31:0] HashMulHi = HashMul[63:32];

  // configuration register indexes
  localparam logic [7:0] REG_SEED       = 8'd0;
  localparam logic [7:0] REG_BIG_ENDIAN = 8'd1;

  typedef struct packed {
    logic        start;
    logic [63:0] operand;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] product;
  } mul_rsp_t;

  function automatic logic [63:0] swap_bytes(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = v[8*(7-i) +: 8];
    end
    return r;
  endfunction

  function automatic logic [63:0] xorshift(input logic [63:0] v);
    return v ^ (v >> HashShift);
  endfunction

endpackage

// ----- design/mxh64_mul.sv -----
// low 64 bits of operand * HashMul, one 32x32 partial product per cycle
module mxh64_mul import mxh64_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  localparam logic [1:0] StepLoLo = 2'd0;
  localparam logic [1:0] StepHiLo = 2'd1;
  localparam logic [1:0] StepLoHi = 2'd2;

  logic [63:0] a_q, a_d;
  logic [63:0] acc_q, acc_d;
  logic [1:0]  step_q, step_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [31:0] op_x, op_y;
  logic [63:0] prod;

  // single shared multiplier
  always_comb begin
    op_x = req_i.operand[31:0];
    op_y = HashMulLo;
    if (!req_i.start) begin
      unique case (step_q)
        StepHiLo: op_x = a_q[63:32];
        StepLoHi: begin
          op_x = a_q[31:0];
          op_y = HashMulHi;
        end
        default: op_x = a_q[31:0];
      endcase
    end
  end

  assign prod = {32'd0, op_x} * {32'd0, op_y};

  always_comb begin
    a_d    = a_q;
    acc_d  = acc_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      a_d    = req_i.operand;
      acc_d  = prod;
      step_d = StepHiLo;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = acc_q + {prod[31:0], 32'd0};
      if (step_q == StepLoHi) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        step_d = StepLoLo;
      end else begin
        step_d = StepLoHi;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepLoLo;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    acc_q <= acc_d;
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

endmodule

// ----- design/multiply_xorshift_hash64.sv -----
// a full block takes three multiplies by the hash constant on the shared 32x32 multiplier, and the
// next transaction is taken only once the sequencer is back in idle; a last item adds two finalize
// multiplies before its hash appears (a partial tail skips the key mixing and takes only those);
// reset clears seed, byte order, running hash and control; the output register lets a new
// transaction in while a hash waits
module multiply_xorshift_hash64 import mxh64_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        first_i,
  input  logic        last_i,
  input  logic [31:0] total_length_i,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  byte_count_i,
  // hash results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] hash_value_o
);

  // one-hot sequencer, one state per multiply in flight
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001, // waiting for a word
    ST_KEY1 = 7'b0000010, // k * M
    ST_KEY2 = 7'b0000100, // (k ^ k>>47) * M
    ST_HASH = 7'b0001000, // (h ^ k) * M
    ST_FIN1 = 7'b0010000, // h * M
    ST_FIN2 = 7'b0100000, // (h ^ h>>47) * M
    ST_EMIT = 7'b1000000  // final xorshift into the output register
  } state_e;

  state_e      state_q, state_d;
  logic [63:0] seed_q;
  logic        big_endian_q;
  logic [63:0] hash_q, hash_d;   // running hash
  logic        last_q, last_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] out_hash_q, out_hash_d;
  mul_req_t    mul_req;
  mul_rsp_t    mul_rsp;

  // helpers for the word arriving in idle
  logic [63:0] start_hash;
  logic [63:0] tail_mask;
  logic        full_block;

  assign start_hash = first_i ? (seed_q ^ ({32'd0, total_length_i} | HashMul)) : hash_q;
  assign tail_mask  = (64'd1 << {byte_count_i[2:0], 3'b000}) - 64'd1;
  // byte counts of 8 and above count as a whole block
  assign full_block = !last_i || (byte_count_i >= 4'd8);

  mxh64_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  always_comb begin
    state_d         = state_q;
    hash_d          = hash_q;
    last_d          = last_q;
    out_valid_d     = out_valid_q && out_stall_i;
    out_hash_d      = out_hash_q;
    mul_req.start   = 1'b0;
    mul_req.operand = mul_rsp.product;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          last_d        = last_i;
          mul_req.start = 1'b1;
          if (full_block) begin
            hash_d          = start_hash;
            mul_req.operand = big_endian_q ? swap_bytes(data_word_i) : data_word_i;
            state_d         = ST_KEY1;
          end else begin
            // partial tail goes straight in, then finalize
            hash_d          = start_hash ^ (data_word_i & tail_mask);
            mul_req.operand = start_hash ^ (data_word_i & tail_mask);
            state_d         = ST_FIN1;
          end
        end
      end
      ST_KEY1: begin
        if (mul_rsp.done) begin
          mul_req.start   = 1'b1;
          mul_req.operand = xorshift(mul_rsp.product);
          state_d         = ST_KEY2;
        end
      end
      ST_KEY2: begin
        if (mul_rsp.done) begin
          hash_d          = hash_q ^ mul_rsp.product;
          mul_req.start   = 1'b1;
          mul_req.operand = hash_q ^ mul_rsp.product;
          state_d         = ST_HASH;
        end
      end
      ST_HASH: begin
        if (mul_rsp.done) begin
          hash_d = mul_rsp.product;
          if (last_q) begin
            mul_req.start   = 1'b1;
            mul_req.operand = mul_rsp.product;
            state_d         = ST_FIN1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FIN1: begin
        if (mul_rsp.done) begin
          mul_req.start   = 1'b1;
          mul_req.operand = xorshift(mul_rsp.product);
          state_d         = ST_FIN2;
        end
      end
      ST_FIN2: begin
        if (mul_rsp.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // multiplier output holds until the output register frees up
        if (!out_valid_q || !out_stall_i) begin
          hash_d      = xorshift(mul_rsp.product);
          out_hash_d  = xorshift(mul_rsp.product);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      seed_q       <= 64'd0;
      big_endian_q <= 1'b0;
      hash_q       <= 64'd0;
      last_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      hash_q      <= hash_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      // register writes, unknown indexes dropped
      if (cfg_we_i && (cfg_index_i == REG_SEED)) begin
        seed_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_index_i == REG_BIG_ENDIAN)) begin
        big_endian_q <= cfg_data_i[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_hash_q <= out_hash_d;
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign hash_value_o = out_hash_q;

endmodule

// ----- design/mxh64_chk.sv -----
module mxh64_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] hash_value_o
);

  // a stalled hash holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hash_value_o))
    else $error("stalled hash changed");

  // the sequencer is busy right after taking a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after transaction");

  // a hash never appears in the cycle after a word is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("hash too early");

  // a new hash only appears while the sequencer is still busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("hash without work in flight");

endmodule

bind multiply_xorshift_hash64 mxh64_chk u_mxh64_chk (.*);

// ----- bench/multiply_xorshift_hash64_tb.sv -----
module multiply_xorshift_hash64_tb;
  import mxh64_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // cycles without any accepted transaction before the run is declared hung
  localparam int unsigned StuckLimit   = 1000;
  // a trailing non-last word may still be in the multiplier when the last hash is out
  localparam int unsigned SettleCycles = 24;
  localparam int unsigned PhaseWords   = 425;

  typedef struct {
    logic        first;
    logic        last;
    logic [31:0] len;
    logic [63:0] data;
    logic [3:0]  count;
  } hash_word_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [7:0]  cfg_index_i    = '0;
  logic [63:0] cfg_data_i     = '0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic        first_i        = 1'b0;
  logic        last_i         = 1'b0;
  logic [31:0] total_length_i = '0;
  logic [63:0] data_word_i    = '0;
  logic [3:0]  byte_count_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [63:0] hash_value_o;

  multiply_xorshift_hash64 u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .first_i        (first_i),
    .last_i         (last_i),
    .total_length_i (total_length_i),
    .data_word_i    (data_word_i),
    .byte_count_i   (byte_count_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hash_value_o   (hash_value_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state: own copy of the registers and of the running hash
  logic [63:0] model_seed;
  logic        model_big_endian;
  logic [63:0] model_hash;

  // hashes predicted but not yet seen on the output
  logic [63:0] hash_q[$];

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned error_count;
  int unsigned words_sent;
  int unsigned hashes_checked;
  int unsigned reg_writes;
  int unsigned quiet_cycles;

  function automatic logic [63:0] reverse_bytes(input logic [63:0] v);
    logic [63:0] r;
    for (int b = 0; b < 8; b++) begin
      r[8*b +: 8] = v[8*(7-b) +: 8];
    end
    return r;
  endfunction

  // multiply, fold the top bits down, multiply again
  function automatic logic [63:0] scramble_key(input logic [63:0] k);
    k = k * HashMul;
    k = k ^ (k >> HashShift);
    k = k * HashMul;
    return k;
  endfunction

  // advance the predicted hash by one accepted word, queue a hash on last
  function automatic void predict_word(input hash_word_t w);
    logic [63:0] h;
    logic [63:0] key;
    if (w.first) begin
      model_hash = model_seed ^ ({32'd0, w.len} | HashMul);
    end
    h = model_hash;
    if (!w.last || w.count >= 4'd8) begin
      // full block, counts above 8 saturate
      key = model_big_endian ? reverse_bytes(w.data) : w.data;
      h = (h ^ scramble_key(key)) * HashMul;
    end else if (w.count != 4'd0) begin
      // partial tail goes in positionally, no key mixing
      h = h ^ (w.data & ((64'd1 << (8 * w.count)) - 64'd1));
    end
    if (w.last) begin
      h = h * HashMul;
      h = h ^ (h >> HashShift);
      h = h * HashMul;
      h = h ^ (h >> HashShift);
      hash_q.push_back(h);
    end
    model_hash = h;
  endfunction

  // receiver side: random stall at the rate of the current phase
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // result checker: every output transaction against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (hash_q.size() == 0) begin
        $error("hash_value with no expected transaction: expected none, actual %h",
               hash_value_o);
        error_count++;
      end else begin
        if (hash_value_o !== hash_q[0]) begin
          $error("hash_value mismatch: expected %h, actual %h", hash_q[0], hash_value_o);
          error_count++;
        end
        void'(hash_q.pop_front());
        hashes_checked++;
      end
    end
  end

  // watchdog on cycles where neither channel moves a transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StuckLimit) begin
        $display("timeout: %0d hashes still expected", hash_q.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // one input transaction, with an optional idle gap in front of it
  task automatic send_word(input logic f, input logic l, input logic [31:0] len,
                           input logic [63:0] data, input logic [3:0] count);
    hash_word_t w;
    w.first = f;
    w.last  = l;
    w.len   = len;
    w.data  = data;
    w.count = count;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    first_i        <= w.first;
    last_i         <= w.last;
    total_length_i <= w.len;
    data_word_i    <= w.data;
    byte_count_i   <= w.count;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_word(w);
    words_sent++;
  endtask

  // register write, only while the block is idle
  task automatic write_reg(input logic [7:0] idx, input logic [63:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_SEED) begin
      model_seed = value;
    end else if (idx == REG_BIG_ENDIAN) begin
      model_big_endian = value[0];
    end
    reg_writes++;
    @(posedge clk_i);
  endtask

  // stop sending, wait for every predicted hash, then let the multiplier settle
  task automatic drain_hashes();
    in_valid_i <= 1'b0;
    while (hash_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // single-word messages at reset settings: field extremes and every tail size
  task automatic test_single_words();
    send_word(1'b1, 1'b1, 32'd0, 64'd0, 4'd8);
    send_word(1'b1, 1'b1, 32'hffff_ffff, '1, 4'd8);
    // empty message: nothing but the length goes in
    send_word(1'b1, 1'b1, 32'd0, 64'h0123_4567_89ab_cdef, 4'd0);
    for (int c = 1; c < 8; c++) begin
      send_word(1'b1, 1'b1, 32'(c), '1, 4'(c));
    end
    // count above 8 on a last word saturates to a full block
    send_word(1'b1, 1'b1, 32'd9, 64'hfedc_ba98_7654_3210, 4'd15);
    drain_hashes();
  endtask

  // multi-word sequencing: ignored counts, restart, continuation without first
  task automatic test_sequencing();
    // byte_count on non-last words does not matter
    send_word(1'b1, 1'b0, 32'd21, {$urandom(), $urandom()}, 4'd3);
    send_word(1'b0, 1'b0, 32'hdead_beef, 64'h8000_0000_0000_0001, 4'd0);
    send_word(1'b0, 1'b1, 32'd0, 64'h1122_3344_5566_7788, 4'd5);
    // first while a message is open drops the old one
    send_word(1'b1, 1'b0, 32'd16, 64'h0f0f_0f0f_0f0f_0f0f, 4'd8);
    send_word(1'b1, 1'b1, 32'd8, 64'hf0f0_f0f0_f0f0_f0f0, 4'd8);
    // no first while closed: carries on from the finalized hash
    send_word(1'b0, 1'b1, 32'd0, 64'h5555_aaaa_5555_aaaa, 4'd8);
    send_word(1'b0, 1'b0, 32'd0, 64'haaaa_5555_aaaa_5555, 4'd8);
    send_word(1'b0, 1'b1, 32'd0, 64'h0000_00ff_ffff_ffff, 4'd7);
    drain_hashes();
  endtask

  // both registers, seed extremes, and writes to indexes that do not exist
  task automatic test_registers();
    write_reg(REG_SEED, '1);
    write_reg(REG_BIG_ENDIAN, '1);
    write_reg(REG_BIG_ENDIAN + 8'd1, {$urandom(), $urandom()});
    write_reg(8'hff, {$urandom(), $urandom()});
    send_word(1'b1, 1'b1, 32'd8, 64'h0102_0304_0506_0708, 4'd8);
    send_word(1'b1, 1'b0, 32'd12, 64'h1122_3344_5566_7788, 4'd8);
    send_word(1'b0, 1'b1, 32'd0, 64'h99aa_bbcc_ddee_ff00, 4'd12);
    drain_hashes();
    write_reg(REG_SEED, 64'd0);
    write_reg(REG_BIG_ENDIAN, 64'hffff_ffff_ffff_fffe);
    send_word(1'b1, 1'b1, 32'd4, 64'h0102_0304_0506_0708, 4'd4);
    drain_hashes();
  endtask

  function automatic logic [3:0] pick_tail_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 4'($urandom_range(0, 7));
    if (r < 80) return 4'd8;
    return 4'($urandom_range(9, 15));
  endfunction

  // one random message: mostly well-formed, sometimes cut short or noisy
  task automatic send_random_message();
    int unsigned n;
    int unsigned kind;
    logic [31:0] len;
    logic [3:0]  tail;
    n    = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
    kind = $urandom_range(0, 99);
    tail = pick_tail_count();
    len  = ($urandom_range(0, 1) == 0) ? (n - 1) * 8 + tail : $urandom();
    if (kind < 8) begin
      // noise word with arbitrary control bits
      send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom(),
                {$urandom(), $urandom()}, 4'($urandom_range(0, 15)));
    end else begin
      // kind 8..13: truncated, no last word, so the next first restarts it
      for (int i = 0; i < n; i++) begin
        if (kind < 14 && i == n - 1) begin
          send_word(i == 0, 1'b0, len, {$urandom(), $urandom()}, 4'd8);
        end else if (i == n - 1) begin
          send_word(i == 0, 1'b1, len, {$urandom(), $urandom()}, tail);
        end else begin
          send_word(i == 0, 1'b0, len, {$urandom(), $urandom()},
                    ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd8);
        end
      end
    end
  endtask

  // one idling phase of random messages under fresh register settings
  task automatic test_random_phase(input int unsigned idle, input int unsigned stall,
                                   input logic [63:0] seed_value, input logic order);
    int unsigned target;
    write_reg(REG_SEED, seed_value);
    write_reg(REG_BIG_ENDIAN, {{63{order}}, order} ^ {$urandom(), $urandom() & ~32'd1});
    idle_pct  = idle;
    stall_pct = stall;
    target    = words_sent + PhaseWords;
    while (words_sent < target) begin
      send_random_message();
      // stretches without any idling inside the idling phases
      if ($urandom_range(0, 49) == 0) begin
        idle_pct  = 0;
        stall_pct = 0;
        repeat (10) send_random_message();
        idle_pct  = idle;
        stall_pct = stall;
      end
    end
    idle_pct  = 0;
    stall_pct = 0;
    drain_hashes();
  endtask

  initial begin
    model_seed       = '0;
    model_big_endian = 1'b0;
    model_hash       = '0;
    idle_pct         = 0;
    stall_pct        = 0;
    words_sent       = 0;
    reg_writes       = 0;

    // reset held low at the start, released on a rising edge
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_words();
    test_sequencing();
    test_registers();
    test_random_phase(0, 0, {$urandom(), $urandom()}, 1'b0);
    test_random_phase(81, 0, '1, 1'b1);
    test_random_phase(0, 81, 64'd0, 1'b0);
    test_random_phase(30, 30, {$urandom(), $urandom()}, 1'b1);

    $display("%0d words hashed, %0d hashes checked under four idling mixes",
             words_sent, hashes_checked);
    $display("%0d register writes: seed at zero, all ones and random, both byte orders",
             reg_writes);
    if (error_count == 0 && hash_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
